// ----- hdl/rmvg_pkg.sv -----
// ----------------------------------------------------------------------------
// rmvg_pkg
// Shared types and constants of the ray marched visibility grid.
// ----------------------------------------------------------------------------
package rmvg_pkg;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_RAY      = 2'd1,
    OP_READ_VIS = 2'd2,
    OP_READ_EXP = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_CENTER,
    ST_IDLE,
    ST_START_RR,
    ST_READ,
    ST_TRIG,
    ST_M_ADDR,
    ST_M_DIV,
    ST_M_WR
  } state_e;

  typedef struct packed {
    op_e                op;
    logic signed [19:0] pos_x;
    logic signed [19:0] pos_y;
    logic [18:0]        radius;
    logic [15:0]        phase;
    logic               hit;
    logic [18:0]        hit_dist;
  } cmd_t;

  localparam int QDEPTH = 2;
  localparam int IN_DATA_W = 88;
  localparam int OUT_DATA_W = 16;

  localparam logic signed [16:0] POLY_C0 = 17'sd77;
  localparam logic signed [16:0] POLY_C1 = 17'sd1306;
  localparam logic signed [16:0] POLY_C2 = 17'sd10583;
  localparam logic signed [16:0] POLY_C3 = 17'sd25736;
  localparam logic signed [16:0] Q14_ONE = 17'sd16384;
  localparam logic [7:0] LEVEL_MAX = 8'd255;
  localparam logic [7:0] FLOOR_RESET = 8'd77;

endpackage

// ----- hdl/rmvg_ram.sv -----
// ----------------------------------------------------------------------------
// rmvg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmvg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/rmvg_front.sv -----
// ----------------------------------------------------------------------------
// rmvg_front
// Accepts items, decodes fields and ray phase, and queues commands.
// ----------------------------------------------------------------------------
module rmvg_front #(
  parameter int RAYS = 180
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rmvg_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  input  logic [1:0]                     s_axis_tuser_i,
  input  logic                           hold_i,
  output logic                           cmd_valid_o,
  output rmvg_pkg::cmd_t                 cmd_o,
  input  logic                           cmd_pop_i
);

  localparam int PW = $clog2(rmvg_pkg::QDEPTH);
  localparam int CNTW = $clog2(rmvg_pkg::QDEPTH + 1);

  logic [15:0] phase_tab [256];

  for (genvar g = 0; g < 256; g++) begin : g_phase
    assign phase_tab[g] = 16'((g * 65536) / RAYS);
  end

  rmvg_pkg::cmd_t queue_q [rmvg_pkg::QDEPTH];
  rmvg_pkg::cmd_t cmd_in;
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] count_q, count_d;
  logic            push, pop;

  always_comb begin
    cmd_in.op       = rmvg_pkg::op_e'(s_axis_tuser_i);
    cmd_in.pos_x    = $signed(s_axis_tdata_i[19:0]);
    cmd_in.pos_y    = $signed(s_axis_tdata_i[39:20]);
    cmd_in.radius   = s_axis_tdata_i[58:40];
    cmd_in.phase    = phase_tab[s_axis_tdata_i[66:59]];
    cmd_in.hit      = s_axis_tdata_i[67];
    cmd_in.hit_dist = s_axis_tdata_i[86:68];
  end

  assign s_axis_tready_o = (count_q != CNTW'(rmvg_pkg::QDEPTH)) && !hold_i;
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = cmd_pop_i && (count_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(rmvg_pkg::QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(rmvg_pkg::QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

  assign cmd_valid_o = (count_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

endmodule

// ----- hdl/rmvg_div.sv -----
// ----------------------------------------------------------------------------
// rmvg_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rmvg_div #(
  parameter int NW = 46,
  parameter int DW = 38,
  parameter int QW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [QW-1:0] quo_o
);

  localparam int KW = $clog2(QW);

  logic          busy_q, done_q;
  logic [KW-1:0] k_q;
  logic [NW-1:0] rem_q, den_sh_q;
  logic [QW-1:0] quo_q;
  logic          fits;

  assign fits = (rem_q >= den_sh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      k_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        k_q    <= KW'(QW - 1);
      end else if (busy_q) begin
        k_q <= k_q - 1'b1;
        if (k_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q    <= num_i;
      den_sh_q <= NW'(den_i) << (QW - 1);
      quo_q    <= '0;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= rem_q - den_sh_q;
      end
      quo_q    <= {quo_q[QW-2:0], fits};
      den_sh_q <= den_sh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- hdl/rmvg_back.sv -----
// ----------------------------------------------------------------------------
// rmvg_back
// Executes start, ray march and read commands on the two grid memories.
// ----------------------------------------------------------------------------
module rmvg_back #(
  parameter int GRID_CELLS = 64,
  parameter int CELL_SHIFT = 8,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cmd_valid_i,
  input  rmvg_pkg::cmd_t                  cmd_i,
  output logic                            cmd_pop_o,
  output logic                            init_busy_o,
  input  logic [7:0]                      floor_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [rmvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int DEPTH = GRID_CELLS * GRID_CELLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = 24;
  localparam int HALF  = (GRID_CELLS << CELL_SHIFT) / 2;
  localparam int SL    = (CELL_SHIFT == 0) ? 0 : CELL_SHIFT - 1;
  localparam int STEP  = 1 << SL;
  localparam int CTR   = HALF >> CELL_SHIFT;
  localparam logic [AW-1:0] CENTER_IDX = AW'(CTR * GRID_CELLS + CTR);

  rmvg_pkg::state_e state_q, state_d;

  logic [AW-1:0]      clr_cnt_q, clr_cnt_d;
  logic               clr_all_q, clr_all_d;
  logic signed [19:0] cx_q, cx_d, cy_q, cy_d;
  logic [18:0]        r_q, r_d;
  logic [37:0]        rr_q, rr_d;
  logic [19:0]        limit_q, limit_d;
  logic [15:0]        phase_q, phase_d;
  logic [20:0]        d_q, d_d;
  logic [43:0]        dd_q, dd_d;
  logic signed [37:0] ax_q, ax_d, ay_q, ay_d;
  logic signed [15:0] cs_q, cs_d, sn_q, sn_d;
  logic signed [16:0] t2_q, t2_d, p_q, p_d;
  logic [2:0]         step_q, step_d;
  logic               sel_q, sel_d;
  logic [AW-1:0]      addr_q, addr_d;
  logic               rd_in_q, rd_in_d, rd_exp_q, rd_exp_d;
  logic               out_valid_q, out_valid_d, out_in_q, out_in_d;
  logic [7:0]         out_level_q, out_level_d;

  // trig datapath
  logic [15:0]        phx;
  logic signed [16:0] t, mul_a, mul_b;
  logic signed [33:0] prod, psh;
  logic signed [15:0] s_clamp, dir;

  always_comb begin
    phx = phase_q + (sel_q ? 16'd16384 : 16'd0);
    if (phx[14]) begin
      t = rmvg_pkg::Q14_ONE - $signed({3'b000, phx[13:0]});
    end else begin
      t = $signed({3'b000, phx[13:0]});
    end
    unique case (step_q)
      3'd0:    begin mul_a = t;    mul_b = t;                end
      3'd1:    begin mul_a = t2_q; mul_b = rmvg_pkg::POLY_C0; end
      3'd2:    begin mul_a = t2_q; mul_b = p_q;              end
      3'd3:    begin mul_a = t2_q; mul_b = p_q;              end
      default: begin mul_a = t;    mul_b = p_q;              end
    endcase
    prod = mul_a * mul_b;
    psh  = prod >>> 14;
    if (psh < 0) begin
      s_clamp = '0;
    end else if (psh > 34'sd16384) begin
      s_clamp = 16'sd16384;
    end else begin
      s_clamp = 16'(psh);
    end
    dir = phx[15] ? -s_clamp : s_clamp;
  end

  // cell lookup, shared by reads and march steps
  logic signed [CW-1:0] dx, dy;
  logic [CW-1:0]        gx, gy;
  logic                 cell_in;
  logic [AW-1:0]        cell_addr;

  always_comb begin
    if (state_q == rmvg_pkg::ST_IDLE) begin
      dx = CW'(cmd_i.pos_x) - CW'(cx_q) + CW'(HALF);
      dy = CW'(cmd_i.pos_y) - CW'(cy_q) + CW'(HALF);
    end else begin
      dx = CW'(ax_q >>> 14) + CW'(HALF);
      dy = CW'(ay_q >>> 14) + CW'(HALF);
    end
    gx = CW'($unsigned(dx) >> CELL_SHIFT);
    gy = CW'($unsigned(dy) >> CELL_SHIFT);
    cell_in = !dx[CW-1] && !dy[CW-1] && (gx < CW'(GRID_CELLS)) && (gy < CW'(GRID_CELLS));
    cell_addr = AW'(gy * GRID_CELLS + gx);
  end

  // memories
  logic          vis_we, exp_we, rd_re;
  logic [AW-1:0] vis_waddr, exp_waddr;
  logic [7:0]    vis_wdata, exp_wdata, vis_rdata, exp_rdata;

  rmvg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_vis_ram (
    .clk_i   (clk_i),
    .we_i    (vis_we),
    .waddr_i (vis_waddr),
    .wdata_i (vis_wdata),
    .re_i    (rd_re),
    .raddr_i (cell_addr),
    .rdata_o (vis_rdata)
  );

  rmvg_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_exp_ram (
    .clk_i   (clk_i),
    .we_i    (exp_we),
    .waddr_i (exp_waddr),
    .wdata_i (exp_wdata),
    .re_i    (rd_re),
    .raddr_i (cell_addr),
    .rdata_o (exp_rdata)
  );

  // level divider
  logic        div_start, div_done;
  logic [37:0] rr_diff;
  logic [45:0] div_num;
  logic [7:0]  div_quo;

  assign rr_diff = rr_q - dd_q[37:0];
  assign div_num = {rr_diff, 8'd0} - 46'(rr_diff);

  rmvg_div #(.NW(46), .DW(38), .QW(8)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (rr_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  logic [19:0] hit_lim;
  logic        out_free;

  assign hit_lim  = 20'(cmd_i.hit_dist) + 20'(1 << (FRAC_BITS - 1));
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    clr_all_d   = clr_all_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    r_d         = r_q;
    rr_d        = rr_q;
    limit_d     = limit_q;
    phase_d     = phase_q;
    d_d         = d_q;
    dd_d        = dd_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    cs_d        = cs_q;
    sn_d        = sn_q;
    t2_d        = t2_q;
    p_d         = p_q;
    step_d      = step_q;
    sel_d       = sel_q;
    addr_d      = addr_q;
    rd_in_d     = rd_in_q;
    rd_exp_d    = rd_exp_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_in_d    = out_in_q;
    out_level_d = out_level_q;
    cmd_pop_o   = 1'b0;
    vis_we      = 1'b0;
    exp_we      = 1'b0;
    vis_waddr   = addr_q;
    exp_waddr   = addr_q;
    vis_wdata   = '0;
    exp_wdata   = '0;
    rd_re       = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      rmvg_pkg::ST_CLEAR: begin
        vis_we    = 1'b1;
        exp_we    = clr_all_q;
        vis_waddr = clr_cnt_q;
        exp_waddr = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_cnt_d = '0;
          state_d   = clr_all_q ? rmvg_pkg::ST_IDLE : rmvg_pkg::ST_CENTER;
          clr_all_d = 1'b0;
        end
      end
      rmvg_pkg::ST_CENTER: begin
        vis_we    = 1'b1;
        exp_we    = 1'b1;
        vis_waddr = CENTER_IDX;
        exp_waddr = CENTER_IDX;
        vis_wdata = rmvg_pkg::LEVEL_MAX;
        exp_wdata = rmvg_pkg::LEVEL_MAX;
        state_d   = rmvg_pkg::ST_IDLE;
      end
      rmvg_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          unique case (cmd_i.op)
            rmvg_pkg::OP_START: begin
              cx_d    = cmd_i.pos_x;
              cy_d    = cmd_i.pos_y;
              r_d     = (cmd_i.radius == '0) ? 19'd1 : cmd_i.radius;
              state_d = rmvg_pkg::ST_START_RR;
            end
            rmvg_pkg::OP_RAY: begin
              limit_d = (cmd_i.hit && (hit_lim < 20'(r_q))) ? hit_lim : 20'(r_q);
              phase_d = cmd_i.phase;
              d_d     = '0;
              dd_d    = '0;
              ax_d    = '0;
              ay_d    = '0;
              step_d  = '0;
              sel_d   = 1'b0;
              state_d = rmvg_pkg::ST_TRIG;
            end
            rmvg_pkg::OP_READ_VIS, rmvg_pkg::OP_READ_EXP: begin
              rd_re    = 1'b1;
              rd_in_d  = cell_in;
              rd_exp_d = (cmd_i.op == rmvg_pkg::OP_READ_EXP);
              state_d  = rmvg_pkg::ST_READ;
            end
          endcase
        end
      end
      rmvg_pkg::ST_START_RR: begin
        rr_d    = 38'(r_q) * 38'(r_q);
        state_d = rmvg_pkg::ST_CLEAR;
      end
      rmvg_pkg::ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_in_d    = rd_in_q;
          out_level_d = !rd_in_q ? 8'd0 : (rd_exp_q ? exp_rdata : vis_rdata);
          state_d     = rmvg_pkg::ST_IDLE;
        end
      end
      rmvg_pkg::ST_TRIG: begin
        step_d = step_q + 1'b1;
        unique case (step_q)
          3'd0: t2_d = 17'(psh);
          3'd1: p_d  = rmvg_pkg::POLY_C1 - 17'(psh);
          3'd2: p_d  = rmvg_pkg::POLY_C2 - 17'(psh);
          3'd3: p_d  = rmvg_pkg::POLY_C3 - 17'(psh);
          default: begin
            step_d = '0;
            sel_d  = 1'b1;
            if (sel_q) begin
              cs_d    = dir;
              state_d = rmvg_pkg::ST_M_ADDR;
            end else begin
              sn_d = dir;
            end
          end
        endcase
      end
      rmvg_pkg::ST_M_ADDR: begin
        if ((d_q >= 21'(limit_q)) || !cell_in) begin
          state_d = rmvg_pkg::ST_IDLE;
        end else begin
          rd_re     = 1'b1;
          addr_d    = cell_addr;
          div_start = 1'b1;
          state_d   = rmvg_pkg::ST_M_DIV;
        end
      end
      rmvg_pkg::ST_M_DIV: begin
        if (div_done) begin
          state_d = rmvg_pkg::ST_M_WR;
        end
      end
      rmvg_pkg::ST_M_WR: begin
        vis_we    = 1'b1;
        exp_we    = 1'b1;
        vis_wdata = (div_quo > vis_rdata) ? div_quo : vis_rdata;
        exp_wdata = (floor_i > exp_rdata) ? floor_i : exp_rdata;
        d_d       = d_q + 21'(STEP);
        dd_d      = dd_q + (44'(d_q) << (SL + 1)) + 44'(STEP * STEP);
        ax_d      = ax_q + (38'(cs_q) <<< SL);
        ay_d      = ay_q + (38'(sn_q) <<< SL);
        state_d   = rmvg_pkg::ST_M_ADDR;
      end
      default: state_d = rmvg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmvg_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_all_q   <= 1'b1;
      cx_q        <= '0;
      cy_q        <= '0;
      r_q         <= 19'd1;
      rr_q        <= 38'd1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_all_q   <= clr_all_d;
      cx_q        <= cx_d;
      cy_q        <= cy_d;
      r_q         <= r_d;
      rr_q        <= rr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    limit_q     <= limit_d;
    phase_q     <= phase_d;
    d_q         <= d_d;
    dd_q        <= dd_d;
    ax_q        <= ax_d;
    ay_q        <= ay_d;
    cs_q        <= cs_d;
    sn_q        <= sn_d;
    t2_q        <= t2_d;
    p_q         <= p_d;
    step_q      <= step_d;
    sel_q       <= sel_d;
    addr_q      <= addr_d;
    rd_in_q     <= rd_in_d;
    rd_exp_q    <= rd_exp_d;
    out_in_q    <= out_in_d;
    out_level_q <= out_level_d;
  end

  assign init_busy_o     = (state_q == rmvg_pkg::ST_CLEAR) && clr_all_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, out_in_q, out_level_q};

endmodule

// ----- hdl/ray_marched_visibility_grid.sv -----
// ----------------------------------------------------------------------------
// ray_marched_visibility_grid
// Fog-of-war visibility and explored grids updated by marched rays.
//
//   channel  dir  handshake             payload
//   s_axis   in   tvalid/tready         tuser op, tdata fields
//   m_axis   out  tvalid/tready         tdata level, in_grid
//   cfg      in   cfg_valid/cfg_ready   explored floor
//
// a ray does its direction setup, then for each half-cell step runs the level
// divider and the grid read-modify-write; a start runs the visibility clearing
// sweep over all GRID_CELLS*GRID_CELLS cells. after reset such a sweep clears
// both grids and no item is taken meanwhile.
// a two-entry queue lets the input side fill while the back end works or
// waits on a stalled output register.
// ----------------------------------------------------------------------------
module ray_marched_visibility_grid #(
  parameter int GRID_CELLS = 64,
  parameter int CELL_SHIFT = 8,
  parameter int RAYS       = 180,
  parameter int FRAC_BITS  = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pos_x, pos_y, view_radius, ray_index, ray_hit, hit_distance
  input  logic [rmvg_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic [1:0]                      s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // level, in_grid
  output logic [rmvg_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [7:0]                      cfg_data_i
);

  logic           cmd_valid, cmd_pop, init_busy;
  rmvg_pkg::cmd_t cmd;
  logic [7:0]     floor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= rmvg_pkg::FLOOR_RESET;
    end else if (cfg_valid_i) begin
      floor_q <= cfg_data_i;
    end
  end

  rmvg_front #(.RAYS(RAYS)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .hold_i          (init_busy),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd),
    .cmd_pop_i       (cmd_pop)
  );

  rmvg_back #(
    .GRID_CELLS (GRID_CELLS),
    .CELL_SHIFT (CELL_SHIFT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (cmd_valid),
    .cmd_i           (cmd),
    .cmd_pop_o       (cmd_pop),
    .init_busy_o     (init_busy),
    .floor_i         (floor_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule
